### hw/rtl/multilevel_feedback_scheduler_top_defines.svh
// assertion macros shared by the scheduler checker
`ifndef MULTILEVEL_FEEDBACK_SCHEDULER_TOP_DEFINES_SVH
`define MULTILEVEL_FEEDBACK_SCHEDULER_TOP_DEFINES_SVH

// clocked assertion with the block reset as disable
`define MFS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// same-cycle implication
`define MFS_ASSERT_IMPL(label, pre, post, msg) \
  `MFS_ASSERT(label, pre |-> post, msg)

`endif

### hw/rtl/mfs_pkg.sv
package mfs_pkg;

  // sizing
  localparam int MAX_JOBS   = 64;
  localparam int NUM_LEVELS = 5;
  localparam int SLOT_W     = $clog2(MAX_JOBS);
  localparam int CNT_W      = $clog2(MAX_JOBS + 1);
  localparam int LIDX_W     = $clog2(NUM_LEVELS);
  localparam int FIFO_DEPTH = NUM_LEVELS * MAX_JOBS;
  localparam int FADDR_W    = $clog2(FIFO_DEPTH);

  // field widths
  localparam int KIND_W  = 3;
  localparam int LEVEL_W = 3;
  localparam int ID_W    = 16;
  localparam int NEED_W  = 16;
  localparam int STAMP_W = 32;
  localparam int SLICE_W = 8;

  localparam logic [SLICE_W-1:0] SLICE_RESET = 8'd10;

  typedef logic [LIDX_W-1:0] lvl_t;
  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  localparam lvl_t LAST_LVL = LIDX_W'(NUM_LEVELS - 1);

  typedef enum logic [KIND_W-1:0] {
    KIND_ACCEPTED = 3'd0,
    KIND_REJECTED = 3'd1,
    KIND_RAN      = 3'd2,
    KIND_FINISHED = 3'd3,
    KIND_IDLE     = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUB_WR,
    ST_DSP_FIFO,
    ST_DSP_REC,
    ST_RESP
  } state_e;

  // one job record, kept in the record memory
  typedef struct packed {
    logic [ID_W-1:0]    job_id;
    lvl_t               first_level;
    logic [NEED_W-1:0]  need;
    logic [NEED_W-1:0]  rem;
    logic [STAMP_W-1:0] first_start;
    logic               has_run;
  } rec_t;

  typedef struct packed {
    kind_e              kind;
    logic [ID_W-1:0]    job_number;
    logic [LEVEL_W-1:0] first_level;
    logic [NEED_W-1:0]  job_need;
    logic [STAMP_W-1:0] start_stamp;
    logic [STAMP_W-1:0] end_stamp;
    logic [STAMP_W-1:0] turnaround;
    logic [LEVEL_W-1:0] final_level;
  } res_t;

endpackage

### hw/rtl/multilevel_feedback_scheduler_top.sv
// multilevel feedback queue scheduler
//
// input channel (in_valid_i / in_ready_o) carries one command per transfer:
// action_i = 0 submits a job at requested_level_i needing time_needed_i,
// action_i = 1 dispatches one turn of the head job of the best level.
// every command yields exactly one result on the output channel
// (out_valid_o / out_ready_i), held in an output register.
// a submit, a rejected submit or an idle dispatch goes through a write or
// response state before the next possible transfer; a dispatch that runs
// a job goes through the queue memory read, then the record memory read,
// then the write-back of record, queue and free list. the result is
// registered and shows in the cycle after the last of these.
// a new command is taken while an earlier result still waits; the block
// stalls in its write-back or response step only while the output
// register is full and not being taken.
// reset clears all queues, the free list and the clock, sets the sequence
// counter to 1 and the slice to 10; the memories need no clearing.
// cfg_we_i writes the time slice; write it only while the block is idle.
module multilevel_feedback_scheduler_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [mfs_pkg::SLICE_W-1:0]  cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         action_i,
  input  logic [mfs_pkg::LEVEL_W-1:0]  requested_level_i,
  input  logic [mfs_pkg::NEED_W-1:0]   time_needed_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [mfs_pkg::KIND_W-1:0]   result_kind_o,
  output logic [mfs_pkg::ID_W-1:0]     job_number_o,
  output logic [mfs_pkg::LEVEL_W-1:0]  first_level_o,
  output logic [mfs_pkg::NEED_W-1:0]   job_need_o,
  output logic [mfs_pkg::STAMP_W-1:0]  start_stamp_o,
  output logic [mfs_pkg::STAMP_W-1:0]  end_stamp_o,
  output logic [mfs_pkg::STAMP_W-1:0]  turnaround_o,
  output logic [mfs_pkg::LEVEL_W-1:0]  final_level_o
);
  import mfs_pkg::*;

  localparam logic ACT_DISPATCH = 1'b1;

  // queue memory address of a position in a level ring
  function automatic logic [FADDR_W-1:0] fifo_addr(lvl_t lvl, slot_t pos);
    return FADDR_W'(lvl) * FADDR_W'(MAX_JOBS) + FADDR_W'(pos);
  endfunction

  function automatic slot_t slot_inc(slot_t s);
    return (s == SLOT_W'(MAX_JOBS - 1)) ? '0 : s + 1'b1;
  endfunction

  state_e state_q, state_d;

  logic [SLICE_W-1:0] slice_q;
  logic [STAMP_W-1:0] clock_q;
  logic [ID_W-1:0]    next_id_q;
  slot_t              head_q  [NUM_LEVELS];
  cnt_t               count_q [NUM_LEVELS];
  cnt_t               fresh_q;
  cnt_t               stk_q;
  logic               out_valid_q;

  lvl_t               lvl_q;
  logic [NEED_W-1:0]  need_q;
  slot_t              slot_q;
  logic               from_stk_q;
  kind_e              resp_kind_q;
  res_t               res_q;

  logic in_fire, out_free, full, any_lvl;
  lvl_t sel_lvl, req_lvl;

  // memory ports
  logic               rec_we, rec_re;
  rec_t               rec_wdata, rec_rd;
  logic               fifo_we, fifo_re;
  logic [FADDR_W-1:0] fifo_waddr, fifo_raddr;
  slot_t              fifo_rd;
  logic               stk_we, stk_re;
  slot_t              stk_rd;

  // control
  logic  alloc, deq, enq, push, res_we;
  slot_t cur_slot, enq_pos;
  lvl_t  enq_lvl;
  res_t  res_d;
  logic [CNT_W:0] pos_sum;

  // turn arithmetic
  logic               fin;
  logic [NEED_W-1:0]  run;
  logic [STAMP_W-1:0] start_v, end_v;
  lvl_t               nlvl;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign full       = (fresh_q == CNT_W'(MAX_JOBS)) && (stk_q == '0);
  assign req_lvl    = (requested_level_i > LEVEL_W'(NUM_LEVELS - 1)) ?
                      LAST_LVL : requested_level_i[LIDX_W-1:0];

  // lowest non-empty level
  always_comb begin
    any_lvl = 1'b0;
    sel_lvl = '0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (count_q[i] != '0) begin
        any_lvl = 1'b1;
        sel_lvl = lvl_t'(i);
      end
    end
  end

  // one turn of the dispatched job
  always_comb begin
    fin     = rec_rd.rem < NEED_W'(slice_q);
    run     = fin ? rec_rd.rem : NEED_W'(slice_q);
    start_v = rec_rd.has_run ? rec_rd.first_start : clock_q;
    end_v   = clock_q + STAMP_W'(run);
    nlvl    = (fin || lvl_q == LAST_LVL) ? lvl_q : lvl_q + 1'b1;
  end

  // tail position of the level being appended to
  always_comb begin
    enq_lvl = (state_q == ST_SUB_WR) ? lvl_q : nlvl;
    pos_sum = (CNT_W + 1)'(head_q[enq_lvl]) + (CNT_W + 1)'(count_q[enq_lvl]);
    enq_pos = (pos_sum >= (CNT_W + 1)'(MAX_JOBS)) ?
              SLOT_W'(pos_sum - (CNT_W + 1)'(MAX_JOBS)) : SLOT_W'(pos_sum);
  end

  assign cur_slot = (state_q == ST_SUB_WR && from_stk_q) ? stk_rd : slot_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (action_i == ACT_DISPATCH) begin
            state_d = any_lvl ? ST_DSP_FIFO : ST_RESP;
          end else begin
            state_d = full ? ST_RESP : ST_SUB_WR;
          end
        end
      end
      ST_DSP_FIFO: state_d = ST_DSP_REC;
      ST_SUB_WR, ST_DSP_REC, ST_RESP: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // memory strobes and result
  always_comb begin
    alloc      = 1'b0;
    deq        = 1'b0;
    enq        = 1'b0;
    push       = 1'b0;
    res_we     = 1'b0;
    rec_we     = 1'b0;
    rec_re     = 1'b0;
    fifo_re    = 1'b0;
    stk_re     = 1'b0;
    rec_wdata  = rec_rd;
    fifo_raddr = fifo_addr(sel_lvl, head_q[sel_lvl]);
    res_d      = '0;
    res_d.kind = resp_kind_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (action_i == ACT_DISPATCH) begin
            fifo_re = any_lvl;
            deq     = any_lvl;
          end else if (!full) begin
            alloc  = 1'b1;
            stk_re = (stk_q != '0);
          end
        end
      end
      ST_DSP_FIFO: rec_re = 1'b1;
      ST_SUB_WR: begin
        if (out_free) begin
          rec_we                = 1'b1;
          enq                   = 1'b1;
          res_we                = 1'b1;
          rec_wdata.job_id      = next_id_q;
          rec_wdata.first_level = lvl_q;
          rec_wdata.need        = need_q;
          rec_wdata.rem         = need_q;
          rec_wdata.first_start = '0;
          rec_wdata.has_run     = 1'b0;
          res_d.kind            = KIND_ACCEPTED;
          res_d.job_number      = next_id_q;
          res_d.first_level     = LEVEL_W'(lvl_q);
          res_d.job_need        = need_q;
          res_d.final_level     = LEVEL_W'(lvl_q);
        end
      end
      ST_DSP_REC: begin
        if (out_free) begin
          rec_we                = 1'b1;
          enq                   = !fin;
          push                  = fin;
          res_we                = 1'b1;
          rec_wdata.rem         = rec_rd.rem - NEED_W'(slice_q);
          rec_wdata.first_start = start_v;
          rec_wdata.has_run     = 1'b1;
          res_d.kind            = fin ? KIND_FINISHED : KIND_RAN;
          res_d.job_number      = rec_rd.job_id;
          res_d.first_level     = LEVEL_W'(rec_rd.first_level);
          res_d.job_need        = rec_rd.need;
          res_d.start_stamp     = start_v;
          res_d.end_stamp       = end_v;
          res_d.turnaround      = end_v - start_v;
          res_d.final_level     = LEVEL_W'(nlvl);
        end
      end
      ST_RESP: res_we = out_free;
      default: ;
    endcase
  end

  assign fifo_we    = enq;
  assign fifo_waddr = fifo_addr(enq_lvl, enq_pos);
  assign stk_we     = push;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      slice_q     <= SLICE_RESET;
      clock_q     <= '0;
      next_id_q   <= ID_W'(1);
      fresh_q     <= '0;
      stk_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head_q[i]  <= '0;
        count_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) slice_q <= cfg_wdata_i;
      if (res_we && state_q == ST_DSP_REC) clock_q <= end_v;
      if (res_we && state_q == ST_SUB_WR) next_id_q <= next_id_q + 1'b1;
      if (alloc && !stk_re) fresh_q <= fresh_q + 1'b1;
      if (stk_re) begin
        stk_q <= stk_q - 1'b1;
      end else if (push) begin
        stk_q <= stk_q + 1'b1;
      end
      // level rings: a dequeue and an append never fall in one cycle
      if (deq) begin
        head_q[sel_lvl]  <= slot_inc(head_q[sel_lvl]);
        count_q[sel_lvl] <= count_q[sel_lvl] - 1'b1;
      end else if (enq) begin
        count_q[enq_lvl] <= count_q[enq_lvl] + 1'b1;
      end
      if (res_we) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // per-command payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      lvl_q       <= (action_i == ACT_DISPATCH) ? sel_lvl : req_lvl;
      need_q      <= time_needed_i;
      resp_kind_q <= (action_i == ACT_DISPATCH) ? KIND_IDLE : KIND_REJECTED;
      from_stk_q  <= (stk_q != '0);
      slot_q      <= fresh_q[SLOT_W-1:0];
    end else if (state_q == ST_DSP_FIFO) begin
      slot_q <= fifo_rd;
    end
    if (res_we) res_q <= res_d;
  end

  // job records
  mfs_ram #(
    .WIDTH ($bits(rec_t)),
    .DEPTH (MAX_JOBS)
  ) u_rec_ram (
    .clk_i   (clk_i),
    .we_i    (rec_we),
    .waddr_i (cur_slot),
    .wdata_i (rec_wdata),
    .re_i    (rec_re),
    .raddr_i (fifo_rd),
    .rdata_o (rec_rd)
  );

  // level rings of slot indices
  mfs_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo_ram (
    .clk_i   (clk_i),
    .we_i    (fifo_we),
    .waddr_i (fifo_waddr),
    .wdata_i (cur_slot),
    .re_i    (fifo_re),
    .raddr_i (fifo_raddr),
    .rdata_o (fifo_rd)
  );

  // stack of released slots
  mfs_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (MAX_JOBS)
  ) u_stk_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_q[SLOT_W-1:0]),
    .wdata_i (slot_q),
    .re_i    (stk_re),
    .raddr_i (SLOT_W'(stk_q - 1'b1)),
    .rdata_o (stk_rd)
  );

  // output ports
  assign out_valid_o   = out_valid_q;
  assign result_kind_o = res_q.kind;
  assign job_number_o  = res_q.job_number;
  assign first_level_o = res_q.first_level;
  assign job_need_o    = res_q.job_need;
  assign start_stamp_o = res_q.start_stamp;
  assign end_stamp_o   = res_q.end_stamp;
  assign turnaround_o  = res_q.turnaround;
  assign final_level_o = res_q.final_level;

endmodule

### hw/rtl/mfs_ram.sv
module mfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, held between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### hw/rtl/mfs_checker.sv
`include "multilevel_feedback_scheduler_top_defines.svh"

module mfs_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         cfg_we_i,
  input logic [mfs_pkg::SLICE_W-1:0]  cfg_wdata_i,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic                         action_i,
  input logic [mfs_pkg::LEVEL_W-1:0]  requested_level_i,
  input logic [mfs_pkg::NEED_W-1:0]   time_needed_i,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [mfs_pkg::KIND_W-1:0]   result_kind_o,
  input logic [mfs_pkg::ID_W-1:0]     job_number_o,
  input logic [mfs_pkg::LEVEL_W-1:0]  first_level_o,
  input logic [mfs_pkg::NEED_W-1:0]   job_need_o,
  input logic [mfs_pkg::STAMP_W-1:0]  start_stamp_o,
  input logic [mfs_pkg::STAMP_W-1:0]  end_stamp_o,
  input logic [mfs_pkg::STAMP_W-1:0]  turnaround_o,
  input logic [mfs_pkg::LEVEL_W-1:0]  final_level_o
);
  import mfs_pkg::*;

  // stalled result stays put
  `MFS_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_kind_o) && $stable(job_number_o) && $stable(end_stamp_o), "result changed while stalled")

  // one command at a time: no transfer in the cycle after one
  `MFS_ASSERT(a_in_gap, in_valid_i && in_ready_o |=> !in_ready_o, "back-to-back command transfer")

  // turnaround is end minus start for any turn result
  `MFS_ASSERT_IMPL(a_turnaround, out_valid_o && (result_kind_o == KIND_RAN || result_kind_o == KIND_FINISHED), turnaround_o == end_stamp_o - start_stamp_o, "turnaround mismatch")

  // accepted submit carries no stamps and keeps its level
  `MFS_ASSERT_IMPL(a_accept_shape, out_valid_o && result_kind_o == KIND_ACCEPTED, start_stamp_o == '0 && end_stamp_o == '0 && final_level_o == first_level_o, "bad accepted result")

endmodule

bind multilevel_feedback_scheduler_top mfs_checker u_mfs_checker (.*);
